### design/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared constants and types for the RAID5 LBA mapper.
// ----------------------------------------------------------------------------
package rlm_pkg;

   localparam int SECTOR_W  = 48;   // address fields on the ports
   localparam int SOFF_W    = 20;
   localparam int UOFF_W    = 16;
   localparam int DEV_W     = 4;
   localparam int CSR_W     = 6;    // widest register
   localparam int CSR_IDX_W = 3;

   localparam int ADDR_BITS_DEF   = 48;
   localparam int MAX_DEVICES_DEF = 16;

   // Quotient bits resolved per divider stage
   localparam int DIV_STEP = 4;

   localparam int UNIT_SHIFT_MAX = 16;
   localparam int DEV_MIN        = 3;
   localparam int ZONE_SHIFT_MIN = 8;
   localparam int ZONE_SHIFT_MAX = 40;

   localparam int RST_UNIT_SHIFT  = 7;
   localparam int RST_DEV_COUNT   = 5;
   localparam int RST_LZONE_SHIFT = 24;
   localparam int RST_PZONE_SHIFT = 22;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNIT_SHIFT   = 3'd0,
      CSR_DEVICE_COUNT = 3'd1,
      CSR_LZONE_SHIFT  = 3'd2,
      CSR_PZONE_SHIFT  = 3'd3,
      CSR_FIXED_PARITY = 3'd4
   } csr_index_type;

endpackage

### design/rlm_req_if.sv
// ----------------------------------------------------------------------------
// rlm_req_if
// Request channel: one logical sector address per word.
// ----------------------------------------------------------------------------
interface rlm_req_if;
   import rlm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SECTOR_W-1:0] logical_sector;

   modport source (output valid, output logical_sector, input ready);
   modport sink   (input valid, input logical_sector, output ready);
endinterface

### design/rlm_rsp_if.sv
// ----------------------------------------------------------------------------
// rlm_rsp_if
// Response channel: one mapped location per word.
// ----------------------------------------------------------------------------
interface rlm_rsp_if;
   import rlm_pkg::*;
   logic                valid;
   logic                ready;
   logic [SECTOR_W-1:0] zone_index;
   logic [SECTOR_W-1:0] stripe_index;
   logic [SECTOR_W-1:0] unit_index;
   logic [DEV_W-1:0]    parity_device;
   logic [DEV_W-1:0]    data_device;
   logic [DEV_W-1:0]    device_sequence;
   logic [SECTOR_W-1:0] physical_sector;
   logic [SOFF_W-1:0]   stripe_offset;
   logic [UOFF_W-1:0]   unit_offset;
   logic                last_unit;

   modport source (output valid, output zone_index, output stripe_index,
                   output unit_index, output parity_device, output data_device,
                   output device_sequence, output physical_sector,
                   output stripe_offset, output unit_offset, output last_unit,
                   input ready);
   modport sink   (input valid, input zone_index, input stripe_index,
                   input unit_index, input parity_device, input data_device,
                   input device_sequence, input physical_sector,
                   input stripe_offset, input unit_offset, input last_unit,
                   output ready);
endinterface

### design/rlm_div_stage.sv
// ----------------------------------------------------------------------------
// rlm_div_stage
// One registered stage of the restoring divider: DIV_STEP quotient bits of
// unit / (dc-1), plus running residues of quotient and zone modulo dc.
// ----------------------------------------------------------------------------
module rlm_div_stage import rlm_pkg::*; #(
   parameter int AW  = ADDR_BITS_DEF,
   parameter int DW  = 5,
   parameter int NB  = 48,
   parameter int STG = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [DW-1:0]     dsr,
   input  logic [DW-1:0]     dc,
   input  logic              prev_valid,
   input  logic [AW-1:0]     prev_unit,
   input  logic [AW-1:0]     prev_zone,
   input  logic [UOFF_W-1:0] prev_uoff,
   input  logic [AW-1:0]     prev_quot,
   input  logic [DW-1:0]     prev_rem,
   input  logic [DW-1:0]     prev_qmod,
   input  logic [DW-1:0]     prev_zmod,
   output logic              next_valid,
   output logic [AW-1:0]     next_unit,
   output logic [AW-1:0]     next_zone,
   output logic [UOFF_W-1:0] next_uoff,
   output logic [AW-1:0]     next_quot,
   output logic [DW-1:0]     next_rem,
   output logic [DW-1:0]     next_qmod,
   output logic [DW-1:0]     next_zmod
);

   localparam int HI = NB - 1 - STG * DIV_STEP;

   logic [NB-1:0]       unit_pad, zone_pad;
   logic [DIV_STEP-1:0] ubits, zbits;
   logic                valid_ff;
   logic [AW-1:0]       unit_ff, zone_ff, quot_ff, quot_in;
   logic [UOFF_W-1:0]   uoff_ff;
   logic [DW-1:0]       rem_ff, qmod_ff, zmod_ff, rem_in, qmod_in, zmod_in;

   assign unit_pad = NB'(prev_unit);
   assign zone_pad = NB'(prev_zone);
   assign ubits    = unit_pad[HI -: DIV_STEP];
   assign zbits    = zone_pad[HI -: DIV_STEP];

   always_comb begin
      logic [DW:0] rw, qw, zw;
      logic        qb;
      rem_in  = prev_rem;
      qmod_in = prev_qmod;
      zmod_in = prev_zmod;
      quot_in = prev_quot;
      for (int k = 0; k < DIV_STEP; k++) begin
         rw = {rem_in, ubits[DIV_STEP-1-k]};
         qb = (rw >= {1'b0, dsr});
         if (qb) begin
            rw = rw - {1'b0, dsr};
         end
         rem_in  = rw[DW-1:0];
         quot_in = {quot_in[AW-2:0], qb};
         qw = {qmod_in, qb};
         if (qw >= {1'b0, dc}) begin
            qw = qw - {1'b0, dc};
         end
         qmod_in = qw[DW-1:0];
         zw = {zmod_in, zbits[DIV_STEP-1-k]};
         if (zw >= {1'b0, dc}) begin
            zw = zw - {1'b0, dc};
         end
         zmod_in = zw[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         unit_ff <= prev_unit;
         zone_ff <= prev_zone;
         uoff_ff <= prev_uoff;
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         qmod_ff <= qmod_in;
         zmod_ff <= zmod_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_unit  = unit_ff;
   assign next_zone  = zone_ff;
   assign next_uoff  = uoff_ff;
   assign next_quot  = quot_ff;
   assign next_rem   = rem_ff;
   assign next_qmod  = qmod_ff;
   assign next_zmod  = zmod_ff;

endmodule

### design/raid5_lba_mapper.sv
// ----------------------------------------------------------------------------
// raid5_lba_mapper
// Maps a logical sector to zone, stripe, unit, parity/data device and
// physical sector in a zoned RAID5 (or RAID4) array.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle unless the
// response side stalls, through stage 0, the divider stages, F1 and the
// output register. The stripe divider is a restoring divider by
// device_count-1 that resolves four quotient bits per stage; the residues
// of stripe and zone modulo device_count ride along in the same stages.
// A stall on the response side freezes the whole pipe; req ready follows
// rsp ready whenever the output register holds a word. Registers are
// clamped into range when written and must only be changed while idle.
// ----------------------------------------------------------------------------
module raid5_lba_mapper import rlm_pkg::*; #(
   parameter int ADDR_BITS   = ADDR_BITS_DEF,
   parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   rlm_req_if.sink              req_chan,
   rlm_rsp_if.source            rsp_chan
);

   localparam int AW   = ADDR_BITS;
   localparam int DW   = $clog2(MAX_DEVICES + 1);
   localparam int NSTG = (AW + DIV_STEP - 1) / DIV_STEP;
   localparam int NB   = NSTG * DIV_STEP;
   localparam int SW   = DW + UOFF_W + 1;
   localparam int DC_RST = (RST_DEV_COUNT > MAX_DEVICES) ? MAX_DEVICES : RST_DEV_COUNT;

   // ---------------- configuration, clamped on write ----------------
   logic [4:0]    us_ff;
   logic [DW-1:0] dc_ff, dsr_ff;   // device count, data units per stripe
   logic [5:0]    lzs_ff, pzs_ff;
   logic          fixed_ff;
   logic [4:0]    v5;
   logic [5:0]    v6;

   assign v5 = csr_data[4:0];
   assign v6 = csr_data[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         us_ff    <= 5'(RST_UNIT_SHIFT);
         dc_ff    <= DW'(DC_RST);
         dsr_ff   <= DW'(DC_RST - 1);
         lzs_ff   <= 6'(RST_LZONE_SHIFT);
         pzs_ff   <= 6'(RST_PZONE_SHIFT);
         fixed_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UNIT_SHIFT: begin
               us_ff <= (int'(v5) > UNIT_SHIFT_MAX) ? 5'(UNIT_SHIFT_MAX) : v5;
            end
            CSR_DEVICE_COUNT: begin
               if (int'(v5) < DEV_MIN) begin
                  dc_ff  <= DW'(DEV_MIN);
                  dsr_ff <= DW'(DEV_MIN - 1);
               end else if (int'(v5) > MAX_DEVICES) begin
                  dc_ff  <= DW'(MAX_DEVICES);
                  dsr_ff <= DW'(MAX_DEVICES - 1);
               end else begin
                  dc_ff  <= DW'(v5);
                  dsr_ff <= DW'(v5 - 5'd1);
               end
            end
            CSR_LZONE_SHIFT: begin
               lzs_ff <= (int'(v6) < ZONE_SHIFT_MIN) ? 6'(ZONE_SHIFT_MIN) :
                         (int'(v6) > ZONE_SHIFT_MAX) ? 6'(ZONE_SHIFT_MAX) : v6;
            end
            CSR_PZONE_SHIFT: begin
               pzs_ff <= (int'(v6) < ZONE_SHIFT_MIN) ? 6'(ZONE_SHIFT_MIN) :
                         (int'(v6) > ZONE_SHIFT_MAX) ? 6'(ZONE_SHIFT_MAX) : v6;
            end
            CSR_FIXED_PARITY: begin
               fixed_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipe control ----------------
   logic o_valid_ff;
   logic adv;

   assign adv            = !o_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ---------------- stage 0: split address ----------------
   logic [AW-1:0]     lba, zoff;
   logic              s0_valid_ff;
   logic [AW-1:0]     s0_unit_ff, s0_zone_ff;
   logic [UOFF_W-1:0] s0_uoff_ff;

   assign lba  = AW'(req_chan.logical_sector);
   assign zoff = lba & ~({AW{1'b1}} << lzs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_zone_ff <= lba >> lzs_ff;
         s0_unit_ff <= zoff >> us_ff;
         s0_uoff_ff <= zoff[UOFF_W-1:0] & ~({UOFF_W{1'b1}} << us_ff);
      end
   end

   // ---------------- divider stages ----------------
   logic              dv_valid [0:NSTG];
   logic [AW-1:0]     dv_unit  [0:NSTG];
   logic [AW-1:0]     dv_zone  [0:NSTG];
   logic [UOFF_W-1:0] dv_uoff  [0:NSTG];
   logic [AW-1:0]     dv_quot  [0:NSTG];
   logic [DW-1:0]     dv_rem   [0:NSTG];
   logic [DW-1:0]     dv_qmod  [0:NSTG];
   logic [DW-1:0]     dv_zmod  [0:NSTG];

   assign dv_valid[0] = s0_valid_ff;
   assign dv_unit[0]  = s0_unit_ff;
   assign dv_zone[0]  = s0_zone_ff;
   assign dv_uoff[0]  = s0_uoff_ff;
   assign dv_quot[0]  = '0;
   assign dv_rem[0]   = '0;
   assign dv_qmod[0]  = '0;
   assign dv_zmod[0]  = '0;

   for (genvar g = 0; g < NSTG; g++) begin : g_div
      rlm_div_stage #(.AW(AW), .DW(DW), .NB(NB), .STG(g)) u_stage (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .dsr        (dsr_ff),
         .dc         (dc_ff),
         .prev_valid (dv_valid[g]),
         .prev_unit  (dv_unit[g]),
         .prev_zone  (dv_zone[g]),
         .prev_uoff  (dv_uoff[g]),
         .prev_quot  (dv_quot[g]),
         .prev_rem   (dv_rem[g]),
         .prev_qmod  (dv_qmod[g]),
         .prev_zmod  (dv_zmod[g]),
         .next_valid (dv_valid[g+1]),
         .next_unit  (dv_unit[g+1]),
         .next_zone  (dv_zone[g+1]),
         .next_uoff  (dv_uoff[g+1]),
         .next_quot  (dv_quot[g+1]),
         .next_rem   (dv_rem[g+1]),
         .next_qmod  (dv_qmod[g+1]),
         .next_zmod  (dv_zmod[g+1])
      );
   end

   // ---------------- F1: rotation sum, shifted terms ----------------
   logic              f1_valid_ff;
   logic [AW-1:0]     f1_zone_ff, f1_unit_ff, f1_stripe_ff, f1_zsh_ff, f1_su_ff;
   logic [UOFF_W-1:0] f1_uoff_ff;
   logic [DW-1:0]     f1_rem_ff, f1_rot_ff, rot_in;
   logic [DW:0]       rot_sum;

   // (stripe + zone) mod dc from the two residues
   assign rot_sum = {1'b0, dv_qmod[NSTG]} + {1'b0, dv_zmod[NSTG]};
   assign rot_in  = (rot_sum >= {1'b0, dc_ff}) ? DW'(rot_sum - {1'b0, dc_ff})
                                               : rot_sum[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= dv_valid[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_zone_ff   <= dv_zone[NSTG];
         f1_unit_ff   <= dv_unit[NSTG];
         f1_stripe_ff <= dv_quot[NSTG];
         f1_uoff_ff   <= dv_uoff[NSTG];
         f1_rem_ff    <= dv_rem[NSTG];
         f1_rot_ff    <= rot_in;
         f1_zsh_ff    <= dv_zone[NSTG] << pzs_ff;
         // low us bits of the shifted stripe are zero, so OR adds the offset
         f1_su_ff     <= (dv_quot[NSTG] << us_ff) | AW'(dv_uoff[NSTG]);
      end
   end

   // ---------------- F2: devices, offsets, output register ----------------
   logic [DW-1:0] parity_in, data_in, seq_in;
   logic [DW:0]   dsum;
   logic [SW-1:0] soff_in;
   logic          last_in;

   always_comb begin
      parity_in = fixed_ff ? (dc_ff - 1'b1) : (dc_ff - 1'b1 - f1_rot_ff);
      dsum      = {1'b0, parity_in} + {1'b0, f1_rem_ff} + 1'b1;
      data_in   = (dsum >= {1'b0, dc_ff}) ? DW'(dsum - {1'b0, dc_ff}) : dsum[DW-1:0];
      seq_in    = (data_in >= parity_in) ? (data_in - parity_in)
                                         : (dc_ff - parity_in + data_in);
      soff_in   = (SW'(f1_rem_ff) << us_ff) + SW'(f1_uoff_ff);
      // last unit of the stripe is data unit dc-2
      last_in   = (f1_rem_ff == dsr_ff - 1'b1);
   end

   logic [AW-1:0]     o_zone_ff, o_stripe_ff, o_unit_ff, o_phys_ff;
   logic [DW-1:0]     o_parity_ff, o_data_ff, o_seq_ff;
   logic [SOFF_W-1:0] o_soff_ff;
   logic [UOFF_W-1:0] o_uoff_ff;
   logic              o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_zone_ff   <= f1_zone_ff;
         o_stripe_ff <= f1_stripe_ff;
         o_unit_ff   <= f1_unit_ff;
         o_phys_ff   <= f1_zsh_ff + f1_su_ff;
         o_parity_ff <= parity_in;
         o_data_ff   <= data_in;
         o_seq_ff    <= seq_in;
         o_soff_ff   <= SOFF_W'(soff_in);
         o_uoff_ff   <= f1_uoff_ff;
         o_last_ff   <= last_in;
      end
   end

   assign rsp_chan.valid           = o_valid_ff;
   assign rsp_chan.zone_index      = SECTOR_W'(o_zone_ff);
   assign rsp_chan.stripe_index    = SECTOR_W'(o_stripe_ff);
   assign rsp_chan.unit_index      = SECTOR_W'(o_unit_ff);
   assign rsp_chan.physical_sector = SECTOR_W'(o_phys_ff);
   assign rsp_chan.parity_device   = DEV_W'(o_parity_ff);
   assign rsp_chan.data_device     = DEV_W'(o_data_ff);
   assign rsp_chan.device_sequence = DEV_W'(o_seq_ff);
   assign rsp_chan.stripe_offset   = o_soff_ff;
   assign rsp_chan.unit_offset     = o_uoff_ff;
   assign rsp_chan.last_unit       = o_last_ff;

   // ---------------- checks ----------------
   a_data_not_parity: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_data_ff != o_parity_ff))
      else $error("data device equals parity device");

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_seq_ff != '0 && o_seq_ff < dc_ff))
      else $error("device sequence out of range");

   a_raid4_parity: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && fixed_ff) |-> (o_parity_ff == dc_ff - 1'b1))
      else $error("fixed parity not on last device");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s0_valid_ff)
      else $error("accepted word lost at pipe entry");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the RAID5 LBA mapper: directed and random sector addresses under
// several register settings and idle/stall phases, each response word compared
// field by field with a predicted mapping.
// ----------------------------------------------------------------------------
module testbench;
   import rlm_pkg::*;

   typedef struct packed {
      logic [SECTOR_W-1:0] zone_index;
      logic [SECTOR_W-1:0] stripe_index;
      logic [SECTOR_W-1:0] unit_index;
      logic [DEV_W-1:0]    parity_device;
      logic [DEV_W-1:0]    data_device;
      logic [DEV_W-1:0]    device_sequence;
      logic [SECTOR_W-1:0] physical_sector;
      logic [SOFF_W-1:0]   stripe_offset;
      logic [UOFF_W-1:0]   unit_offset;
      logic                last_unit;
   } mapping_type;

   logic clock = 0;
   logic reset = 1;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   rlm_req_if req_chan ();
   rlm_rsp_if rsp_chan ();

   raid5_lba_mapper dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_data(csr_data), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // register copies as written (raw, clamped at use)
   logic [4:0] cfg_unit_shift = 5'(RST_UNIT_SHIFT);
   logic [4:0] cfg_dev_count  = 5'(RST_DEV_COUNT);
   logic [5:0] cfg_lzone      = 6'(RST_LZONE_SHIFT);
   logic [5:0] cfg_pzone      = 6'(RST_PZONE_SHIFT);
   logic       cfg_fixed      = 0;

   logic [SECTOR_W-1:0] sector_queue[$];
   mapping_type         mapping_queue[$];
   int                  error_count = 0;
   int                  send_idle_pct = 0;   // sender gap, percent
   int                  recv_stall_pct = 0;  // receiver stall, percent
   bit                  hold_sender = 0;
   logic                req_taken = 0;       // request word accepted at last edge

   function automatic mapping_type map_sector(logic [SECTOR_W-1:0] lba);
      longint unsigned us, dc, lzs, pzs, usize, ssize, zone, zoff;
      longint unsigned stripe, unit, uoff, soff, par, data, seq, phys;
      mapping_type m;
      us  = (cfg_unit_shift > UNIT_SHIFT_MAX) ? UNIT_SHIFT_MAX : cfg_unit_shift;
      dc  = (cfg_dev_count < DEV_MIN) ? DEV_MIN :
            (cfg_dev_count > MAX_DEVICES_DEF) ? MAX_DEVICES_DEF : cfg_dev_count;
      lzs = (cfg_lzone < ZONE_SHIFT_MIN) ? ZONE_SHIFT_MIN :
            (cfg_lzone > ZONE_SHIFT_MAX) ? ZONE_SHIFT_MAX : cfg_lzone;
      pzs = (cfg_pzone < ZONE_SHIFT_MIN) ? ZONE_SHIFT_MIN :
            (cfg_pzone > ZONE_SHIFT_MAX) ? ZONE_SHIFT_MAX : cfg_pzone;
      usize  = 64'd1 << us;
      ssize  = (dc - 1) << us;
      zone   = lba >> lzs;
      zoff   = lba & ((64'd1 << lzs) - 1);
      stripe = zoff / ssize;
      unit   = zoff >> us;
      uoff   = zoff & (usize - 1);
      soff   = zoff % ssize;
      par    = cfg_fixed ? dc - 1 : dc - ((stripe + zone) % dc) - 1;
      data   = (par + (unit % (dc - 1)) + 1) % dc;
      seq    = (data >= par) ? data - par : dc - par + data;
      phys   = (zone << pzs) + stripe * usize + uoff;
      m.zone_index      = zone[SECTOR_W-1:0];
      m.stripe_index    = stripe[SECTOR_W-1:0];
      m.unit_index      = unit[SECTOR_W-1:0];
      m.parity_device   = par[DEV_W-1:0];
      m.data_device     = data[DEV_W-1:0];
      m.device_sequence = seq[DEV_W-1:0];
      m.physical_sector = phys[SECTOR_W-1:0];
      m.stripe_offset   = soff[SOFF_W-1:0];
      m.unit_offset     = uoff[UOFF_W-1:0];
      m.last_unit       = (ssize - soff) <= usize;
      return m;
   endfunction

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // driver: valid/data change on the falling edge only
   initial begin
      req_chan.valid = 0;
      req_chan.logical_sector = '0;
      rsp_chan.ready = 0;
   end

   // acceptance is taken at the rising edge; ready may move after it
   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_chan.valid || req_taken) begin
            // previous word gone (or none held): consider the next one
            if (sector_queue.size() != 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid <= 1;
               req_chan.logical_sector <= sector_queue[0];
               mapping_queue.push_back(map_sector(sector_queue[0]));
               void'(sector_queue.pop_front());
            end else begin
               req_chan.valid <= 0;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // note: expectation queued when the word is presented; acceptance follows
   // before any response to it, since the word must first pass the pipe registers.

   // monitor
   always @(posedge clock) begin
      mapping_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.zone_index, rsp_chan.stripe_index, rsp_chan.unit_index,
                 rsp_chan.parity_device, rsp_chan.data_device,
                 rsp_chan.device_sequence, rsp_chan.physical_sector,
                 rsp_chan.stripe_offset, rsp_chan.unit_offset, rsp_chan.last_unit};
         if (mapping_queue.size() == 0) begin
            report("response word with nothing expected", got.zone_index, 0);
         end else begin
            want = mapping_queue.pop_front();
            if (got.zone_index != want.zone_index)
               report("zone_index", got.zone_index, want.zone_index);
            if (got.stripe_index != want.stripe_index)
               report("stripe_index", got.stripe_index, want.stripe_index);
            if (got.unit_index != want.unit_index)
               report("unit_index", got.unit_index, want.unit_index);
            if (got.parity_device != want.parity_device)
               report("parity_device", got.parity_device, want.parity_device);
            if (got.data_device != want.data_device)
               report("data_device", got.data_device, want.data_device);
            if (got.device_sequence != want.device_sequence)
               report("device_sequence", got.device_sequence, want.device_sequence);
            if (got.physical_sector != want.physical_sector)
               report("physical_sector", got.physical_sector, want.physical_sector);
            if (got.stripe_offset != want.stripe_offset)
               report("stripe_offset", got.stripe_offset, want.stripe_offset);
            if (got.unit_offset != want.unit_offset)
               report("unit_offset", got.unit_offset, want.unit_offset);
            if (got.last_unit != want.last_unit)
               report("last_unit", got.last_unit, want.last_unit);
         end
      end
   end

   // wait until driver drained, pipe empty
   task automatic drain();
      while (sector_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (mapping_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         CSR_UNIT_SHIFT:   cfg_unit_shift = val[4:0];
         CSR_DEVICE_COUNT: cfg_dev_count  = val[4:0];
         CSR_LZONE_SHIFT:  cfg_lzone      = val[5:0];
         CSR_PZONE_SHIFT:  cfg_pzone      = val[5:0];
         CSR_FIXED_PARITY: cfg_fixed      = val[0];
         default: ;
      endcase
   endtask

   // random address: mostly low addresses (within few zones), some full width
   function automatic logic [SECTOR_W-1:0] rand_sector();
      logic [SECTOR_W-1:0] a;
      a = SECTOR_W'({$urandom, $urandom});
      case ($urandom_range(3))
         0: return a;
         1: return a & ((48'd1 << (cfg_lzone + 2)) - 1);
         2: return a & 48'hFFFFF;
         default: return a >> $urandom_range(47);
      endcase
   endfunction

   initial begin
      int phase;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes under reset settings, then extreme registers
      sector_queue.push_back('0);
      sector_queue.push_back('1);
      sector_queue.push_back(48'h555555555555);
      sector_queue.push_back(48'hAAAAAAAAAAAA);
      sector_queue.push_back(48'd511);   // last unit of first stripe
      sector_queue.push_back(48'd512);
      sector_queue.push_back(48'hFFFFFF);
      sector_queue.push_back(48'h1000000);
      drain();

      // out-of-range values saturate; wrap of physical address
      write_csr(CSR_UNIT_SHIFT, 6'd31);
      write_csr(CSR_DEVICE_COUNT, 6'd0);
      write_csr(CSR_LZONE_SHIFT, 6'd63);
      write_csr(CSR_PZONE_SHIFT, 6'd0);
      write_csr(CSR_FIXED_PARITY, 6'd1);
      sector_queue.push_back('1);
      sector_queue.push_back('0);
      sector_queue.push_back(48'h0000FFFFFFFF);
      sector_queue.push_back(48'hFFFF00000000);
      drain();
      write_csr(CSR_UNIT_SHIFT, 6'd0);
      write_csr(CSR_DEVICE_COUNT, 6'd31);
      write_csr(CSR_LZONE_SHIFT, 6'd0);
      write_csr(CSR_PZONE_SHIFT, 6'd63);
      write_csr(CSR_FIXED_PARITY, 6'd0);
      sector_queue.push_back('1);
      sector_queue.push_back(48'h00000000FF);
      sector_queue.push_back(48'h800000000000);
      sector_queue.push_back(48'd14);
      sector_queue.push_back(48'd15);
      drain();

      // random phases: settings and idling change between them
      for (phase = 0; phase < 8; phase++) begin
         write_csr(CSR_UNIT_SHIFT, 6'((phase == 1) ? 16 : $urandom_range(17)));
         write_csr(CSR_DEVICE_COUNT, 6'((phase == 1) ? 16 : $urandom_range(2, 17)));
         write_csr(CSR_LZONE_SHIFT, 6'((phase == 2) ? 40 : $urandom_range(7, 41)));
         write_csr(CSR_PZONE_SHIFT, 6'((phase == 2) ? 8 : $urandom_range(7, 41)));
         write_csr(CSR_FIXED_PARITY, 6'($urandom_range(1)));
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         repeat (60) sector_queue.push_back(rand_sector());
         if (phase == 3) begin
            // sender holds off until every expected word has arrived
            while (sector_queue.size() > 30) @(posedge clock);
            hold_sender = 1;
            while (req_chan.valid) @(posedge clock);
            while (mapping_queue.size() != 0) @(posedge clock);
            hold_sender = 0;
         end
         repeat (65) sector_queue.push_back(rand_sector());
         drain();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule

### raid5_lba_mapper.f
design/rlm_pkg.sv
design/rlm_req_if.sv
design/rlm_rsp_if.sv
design/rlm_div_stage.sv
design/raid5_lba_mapper.sv
tb/testbench.sv
